[rtl/r50fp_pkg.sv]
// Package for the radix-50 file name packer: code type, character constants,
// the radix-50 character map and the three-character packing function.
// Depends on nothing; used by radix50_filename_pack.
`timescale 1ns / 1ps

package r50fp_pkg;

    localparam int CODE_W   = 6;
    localparam int WORD_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int NAME_LEN = 6;
    localparam int EXT_LEN  = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CHAR_TERM  = 8'h00;
    localparam char_t CHAR_SLASH = 8'h2F;
    localparam char_t CHAR_DOT   = 8'h2E;
    localparam char_t LOWER_BIT  = 8'h20;

    localparam code_t CODE_SPACE  = 6'd0;
    localparam code_t CODE_DOLLAR = 6'd27;
    localparam code_t CODE_DOT    = 6'd28;
    localparam code_t CODE_QUERY  = 6'd29;
    localparam code_t CODE_DIGIT0 = 6'd30;

    localparam logic [10:0] R50_BASE_SQ = 11'd1600;
    localparam logic [5:0]  R50_BASE    = 6'd40;

    // Maps a byte, folded to lower case, onto its radix-50 code.
    function automatic code_t map_code(input char_t b);
        char_t c;
        code_t r;
        c = b | LOWER_BIT;
        r = CODE_QUERY;
        if (c == 8'h20)
        begin
            r = CODE_SPACE;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = code_t'(c - 8'h60);
        end
        else if (c == 8'h24)
        begin
            r = CODE_DOLLAR;
        end
        else if (c == 8'h2E)
        begin
            r = CODE_DOT;
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r = code_t'(c - 8'h30) + CODE_DIGIT0;
        end
        return r;
    endfunction

    // Packs three codes, first one most significant; at most 63999 for codes of 39 or less.
    function automatic word_t pack3(input code_t c0, input code_t c1, input code_t c2);
        logic [16:0] p0;
        logic [11:0] p1;
        p0 = 17'(c0) * 17'(R50_BASE_SQ);
        p1 = 12'(c1) * 12'(R50_BASE);
        return word_t'(p0 + 17'(p1) + 17'(c2));
    endfunction

endpackage

[rtl/radix50_filename_pack.sv]
// A terminating zero byte passes from the input register into the result register once
// that register is free or being emptied, and its result item is taken from there.
// Throughput: one byte item per cycle, sustained while the output side takes results.
// Reset (rst_n, asynchronous, active low) empties both registers and clears the gathered
// name and extension to spaces, as does every terminator or slash.
// Depends on r50fp_pkg.
`timescale 1ns / 1ps

module radix50_filename_pack
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // Fields from bit 0 up: char_code [7:0].
    input  r50fp_pkg::char_t        s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // Fields from bit 0 up: name_word_high [15:0], name_word_low [31:16],
    // extension_word [47:32].
    output logic [47:0]             m_axis_tdata
);
    import r50fp_pkg::*;

    // Input register: holds one byte item until the processing stage takes it.
    logic   in_valid_reg, in_valid_next;
    char_t  in_char_reg;

    // Gathered state of the current path name.
    code_t        name_codes_reg [NAME_LEN];
    code_t        name_codes_next [NAME_LEN];
    code_t        ext_codes_reg [EXT_LEN];
    code_t        ext_codes_next [EXT_LEN];
    logic [2:0]   name_count_reg, name_count_next;
    logic [1:0]   ext_count_reg, ext_count_next;
    logic         in_ext_reg, in_ext_next;

    // Result register.
    logic         out_valid_reg, out_valid_next;
    logic [47:0]  out_data_reg, out_data_next;

    logic   advance;
    logic   in_fire;
    logic   is_term;
    logic   is_slash;
    logic   is_dot;
    code_t  mapped;

    // The processing stage moves whenever the result register is free or being emptied,
    // whether or not the item in hand yields a result.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign in_fire       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign is_term  = (in_char_reg == CHAR_TERM);
    assign is_slash = (in_char_reg == CHAR_SLASH);
    assign is_dot   = (in_char_reg == CHAR_DOT);
    assign mapped   = map_code(in_char_reg);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        else if (in_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Buffer update for one byte. A terminator or a slash empties everything; the first dot
    // opens the extension; other bytes fill the next free place or are dropped once full.
    always_comb
    begin
        name_codes_next = name_codes_reg;
        ext_codes_next  = ext_codes_reg;
        name_count_next = name_count_reg;
        ext_count_next  = ext_count_reg;
        in_ext_next     = in_ext_reg;
        if (in_fire)
        begin
            if (is_term || is_slash)
            begin
                for (int i = 0; i < NAME_LEN; i++)
                begin
                    name_codes_next[i] = CODE_SPACE;
                end
                for (int i = 0; i < EXT_LEN; i++)
                begin
                    ext_codes_next[i] = CODE_SPACE;
                end
                name_count_next = '0;
                ext_count_next  = '0;
                in_ext_next     = 1'b0;
            end
            else if (!in_ext_reg)
            begin
                if (is_dot)
                begin
                    in_ext_next = 1'b1;
                end
                else if (name_count_reg < 3'(NAME_LEN))
                begin
                    for (int i = 0; i < NAME_LEN; i++)
                    begin
                        if (name_count_reg == 3'(i))
                        begin
                            name_codes_next[i] = mapped;
                        end
                    end
                    name_count_next = name_count_reg + 3'd1;
                end
            end
            else if (ext_count_reg < 2'(EXT_LEN))
            begin
                for (int i = 0; i < EXT_LEN; i++)
                begin
                    if (ext_count_reg == 2'(i))
                    begin
                        ext_codes_next[i] = mapped;
                    end
                end
                ext_count_next = ext_count_reg + 2'd1;
            end
        end
    end

    // Result register: loaded on a terminator, emptied when the output side takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire && is_term)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {pack3(ext_codes_reg[0], ext_codes_reg[1], ext_codes_reg[2]),
                              pack3(name_codes_reg[3], name_codes_reg[4], name_codes_reg[5]),
                              pack3(name_codes_reg[0], name_codes_reg[1], name_codes_reg[2])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            name_count_reg <= '0;
            ext_count_reg  <= '0;
            in_ext_reg     <= 1'b0;
            for (int i = 0; i < NAME_LEN; i++)
            begin
                name_codes_reg[i] <= CODE_SPACE;
            end
            for (int i = 0; i < EXT_LEN; i++)
            begin
                ext_codes_reg[i] <= CODE_SPACE;
            end
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            name_count_reg <= name_count_next;
            ext_count_reg  <= ext_count_next;
            in_ext_reg     <= in_ext_next;
            name_codes_reg <= name_codes_next;
            ext_codes_reg  <= ext_codes_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_name_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        name_count_reg <= 3'(NAME_LEN))
        else $error("name count beyond the name length");

    a_ext_implies_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ext_count_reg != 2'd0 |-> in_ext_reg)
        else $error("extension characters gathered outside the extension");

    a_result_from_term: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && is_term))
        else $error("result appeared without a terminator");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_term |=> name_count_reg == 3'd0 && ext_count_reg == 2'd0 && !in_ext_reg)
        else $error("terminator did not clear the gathered name");
`endif

endmodule
